// ===== sv/rv_exu_pkg.sv =====
// package: constants, opcodes, status codes, controller types for the execute unit
package rv_exu_pkg;

	localparam int MemBytes = 4096;
	localparam int MemAw = $clog2(MemBytes);
	localparam int MemWords = MemBytes / 4;
	localparam int WordAw = $clog2(MemWords);

	localparam logic [6:0] OP_REG = 7'd51;
	localparam logic [6:0] OP_IMM = 7'd19;
	localparam logic [6:0] OP_LOAD = 7'd3;
	localparam logic [6:0] OP_STORE = 7'd35;
	localparam logic [6:0] OP_BRANCH = 7'd99;
	localparam logic [6:0] OP_JAL = 7'd111;
	localparam logic [6:0] OP_LUI = 7'd55;
	localparam logic [6:0] OP_SYSTEM = 7'd115;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_PRINT = 3'd1;
	localparam logic [2:0] ST_EXIT = 3'd2;
	localparam logic [2:0] ST_ILLEGAL = 3'd3;
	localparam logic [2:0] ST_BADADDR = 3'd4;
	localparam logic [2:0] ST_HALTED = 3'd5;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_MEM,
		S_OUT
	} exu_state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic take;
		logic exec;
		logic div_start;
		logic div_step;
		logic mem_finish;
		logic out_load;
	} exu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic need_div;
		logic need_mem;
		logic div_done;
	} exu_sts_t;

endpackage

// ===== sv/rv_exu_ram.sv =====
// generic single port ram with registered read
module rv_exu_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	input  logic [Width/8-1:0]       wstrb,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		for (int i = 0; i < Width / 8; i++) begin
			if (we && wstrb[i]) begin
				mem[addr][8*i +: 8] <= wdata[8*i +: 8];
			end
		end
		rdata <= mem[addr];
	end
endmodule

// ===== sv/rv_exu_ctrl.sv =====
// controller state machine for the execute unit
module rv_exu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  rv_exu_pkg::exu_sts_t   sts,
	output rv_exu_pkg::exu_cmd_t   cmd
);
	import rv_exu_pkg::*;

	exu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_READ;
			S_READ:  state_d = S_EXEC;
			S_EXEC: begin
				if (sts.need_div) state_d = S_DIV;
				else if (sts.need_mem) state_d = S_MEM;
				else state_d = S_OUT;
			end
			S_DIV:   if (sts.div_done) state_d = S_OUT;
			S_MEM:   state_d = S_OUT;
			S_OUT:   if (!out_valid || !out_stall) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// the result holding registers are complete only once in S_OUT
	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE:  cmd.take = in_valid;
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.div_start = sts.need_div;
			end
			S_DIV:   cmd.div_step = 1'b1;
			S_MEM:   cmd.mem_finish = 1'b1;
			S_OUT:   cmd.out_load = !out_valid || !out_stall;
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == S_IDLE)
		else $error("item taken while busy");
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == S_READ)
		else $error("read did not follow take");
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_done) |=> state_q != S_DIV)
		else $error("divider stuck");
`endif
endmodule

// ===== sv/rv_exu_dp.sv =====
// datapath: register file, memory, alu, serial divider and result register
module rv_exu_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           instr_word,
	input  rv_exu_pkg::exu_cmd_t  cmd,
	input  logic                  out_stall,
	output rv_exu_pkg::exu_sts_t  sts,
	output logic                  valid,
	output logic [2:0]            status,
	output logic [31:0]           next_pc,
	output logic                  reg_write,
	output logic [4:0]            dest_reg,
	output logic [31:0]           write_value,
	output logic signed [31:0]    print_value
);
	import rv_exu_pkg::*;

	logic [31:0] rf_q [32];
	logic [31:0] pc_q, w_q, a_q, b_q, a0_q, a1_q;
	logic halted_q;
	logic [WordAw:0] clr_cnt_q;

	// result holding
	logic [2:0] r_status_q;
	logic [31:0] r_npc_q, r_val_q, r_pv_q;
	logic r_wr_q;
	logic [4:0] r_rd_q;

	// memory access
	logic [31:0] ram_rdata;
	logic [1:0] mem_off_q, mem_sz_q;

	// divider
	logic [31:0] dq_q, dr_q, dd_q;
	logic [32:0] drem_q;
	logic [5:0] dcnt_q;
	logic dneg_q, drneg_q, dis_rem_q, dspec_q;
	logic [31:0] dspec_val_q;

	logic [6:0] op;
	logic [4:0] rd, r1, r2;
	logic [2:0] f3;
	logic [6:0] f7;
	assign op = w_q[6:0];
	assign rd = w_q[11:7];
	assign f3 = w_q[14:12];
	assign r1 = w_q[19:15];
	assign r2 = w_q[24:20];
	assign f7 = w_q[31:25];

	logic [31:0] imm_i, imm_s, off_b, off_j, addr;
	assign imm_i = {{20{w_q[31]}}, w_q[31:20]};
	assign imm_s = {{20{w_q[31]}}, w_q[31:25], w_q[11:7]};
	assign off_b = {{19{w_q[31]}}, w_q[31], w_q[7], w_q[30:25], w_q[11:8], 1'b0};
	assign off_j = {{11{w_q[31]}}, w_q[31], w_q[19:12], w_q[20], w_q[30:21], 1'b0};
	assign addr = a_q + ((op == OP_STORE) ? imm_s : imm_i);

	// decode and simple alu
	logic [2:0] e_status;
	logic [31:0] e_npc, e_val, e_pv;
	logic e_wr, e_div, e_mem, e_store;
	logic [63:0] prod;
	logic [32:0] sa, sb;
	logic [1:0] size_m1;
	logic range_ok;
	logic [4:0] sh;

	assign sa = {a_q[31], a_q};
	assign sb = {b_q[31], b_q};

	always_comb begin
		e_status = ST_OK;
		e_npc = pc_q + 32'd4;
		e_val = '0;
		e_pv = '0;
		e_wr = 1'b0;
		e_div = 1'b0;
		e_mem = 1'b0;
		e_store = 1'b0;
		prod = '0;
		size_m1 = 2'((32'd1 << f3[1:0]) - 32'd1);
		range_ok = ({1'b0, addr} + {31'd0, size_m1} + 33'd1) <= 33'(MemBytes);
		sh = w_q[24:20];
		if (halted_q) begin
			e_status = ST_HALTED;
			e_npc = pc_q;
		end else begin
			case (op)
				OP_REG: begin
					e_wr = 1'b1;
					if (f7 == 7'd0) begin
						case (f3)
							3'd0: e_val = a_q + b_q;
							3'd1: e_val = a_q << b_q[4:0];
							3'd2: e_val = {31'd0, $signed(sa) < $signed(sb)};
							3'd4: e_val = a_q ^ b_q;
							3'd5: e_val = a_q >> b_q[4:0];
							3'd6: e_val = a_q | b_q;
							3'd7: e_val = a_q & b_q;
							default: e_status = ST_ILLEGAL;
						endcase
					end else if (f7 == 7'd32 && f3 == 3'd0) begin
						e_val = a_q - b_q;
					end else if (f7 == 7'd32 && f3 == 3'd5) begin
						e_val = 32'($signed(a_q) >>> b_q[4:0]);
					end else if (f7 == 7'd1 && f3 == 3'd0) begin
						prod = 64'(a_q * b_q);
						e_val = prod[31:0];
					end else if (f7 == 7'd1 && f3 == 3'd1) begin
						prod = 64'($signed(a_q) * $signed(b_q));
						e_val = prod[63:32];
					end else if (f7 == 7'd1 && (f3 == 3'd4 || f3 == 3'd6)) begin
						e_div = 1'b1;
					end else begin
						e_status = ST_ILLEGAL;
					end
				end
				OP_IMM: begin
					e_wr = 1'b1;
					case (f3)
						3'd0: e_val = a_q + imm_i;
						3'd1: if (f7 == 7'd0) e_val = a_q << sh; else e_status = ST_ILLEGAL;
						3'd2: e_val = {31'd0, $signed(sa) < $signed({imm_i[31], imm_i})};
						3'd4: e_val = a_q ^ imm_i;
						3'd5: begin
							if (f7 == 7'd0) e_val = a_q >> sh;
							else if (f7 == 7'd32) e_val = 32'($signed(a_q) >>> sh);
							else e_status = ST_ILLEGAL;
						end
						3'd6: e_val = a_q | imm_i;
						3'd7: e_val = a_q & imm_i;
						default: e_status = ST_ILLEGAL;
					endcase
				end
				OP_LOAD, OP_STORE: begin
					if (f3 > 3'd2) e_status = ST_ILLEGAL;
					else if (!range_ok) e_status = ST_BADADDR;
					else begin
						e_mem = 1'b1;
						e_store = (op == OP_STORE);
						e_wr = (op == OP_LOAD);
					end
				end
				OP_BRANCH: begin
					if (f3 == 3'd0) begin
						if (a_q == b_q) e_npc = pc_q + off_b;
					end else if (f3 == 3'd1) begin
						if (a_q != b_q) e_npc = pc_q + off_b;
					end else begin
						e_status = ST_ILLEGAL;
					end
				end
				OP_JAL: begin
					e_wr = 1'b1;
					e_val = pc_q + 32'd4;
					e_npc = pc_q + off_j;
				end
				OP_LUI: begin
					e_wr = 1'b1;
					e_val = {w_q[31:12], 12'd0};
				end
				OP_SYSTEM: begin
					if (a0_q == 32'd1) begin
						e_status = ST_PRINT;
						e_pv = a1_q;
					end else if (a0_q == 32'd10) begin
						e_status = ST_EXIT;
						e_npc = pc_q;
					end else begin
						e_status = ST_ILLEGAL;
					end
				end
				default: e_status = ST_ILLEGAL;
			endcase
			if (e_status == ST_ILLEGAL || e_status == ST_BADADDR) begin
				e_wr = 1'b0;
				e_div = 1'b0;
				e_mem = 1'b0;
				e_store = 1'b0;
				e_npc = pc_q;
			end
		end
		if (rd == 5'd0) e_wr = 1'b0;
		if (!e_wr) e_val = '0;
	end

	// memory is four byte lanes, each with its own word address, so a misaligned
	// access that crosses a word boundary still needs only a single ram access
	logic [7:0] bram_rdata [4];
	logic [MemAw-1:0] byte_addr [4];
	logic [WordAw-1:0] lane_addr [4];
	logic [3:0] lane_we;
	logic [7:0] lane_wd [4];
	logic [1:0] base_lane;
	logic [MemAw-1:0] base_addr;
	assign base_addr = addr[MemAw-1:0];
	assign base_lane = base_addr[1:0];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [1:0] rel;
			rel = 2'(k) - base_lane;
			byte_addr[k] = base_addr + MemAw'(rel);
			lane_addr[k] = byte_addr[k][MemAw-1:2];
			lane_we[k] = cmd.exec && e_store && ({1'b0, rel} <= {1'b0, size_m1});
			lane_wd[k] = b_q[8*rel +: 8];
			if (cmd.clr_step) begin
				lane_addr[k] = clr_cnt_q[WordAw-1:0];
				lane_we[k] = 1'b1;
				lane_wd[k] = '0;
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_lane
		rv_exu_ram #(.Width(8), .Depth(MemWords)) u_ram (
			.clk   (clk),
			.we    (lane_we[k]),
			.addr  (lane_addr[k]),
			.wdata (lane_wd[k]),
			.wstrb (1'b1),
			.rdata (bram_rdata[k])
		);
	end

	assign ram_rdata = {bram_rdata[3], bram_rdata[2], bram_rdata[1], bram_rdata[0]};

	logic [31:0] ld_raw, ld_val;
	always_comb begin
		ld_raw = ram_rdata >> {mem_off_q, 3'd0};
		ld_raw = ld_raw | (ram_rdata << {~mem_off_q + 2'd1, 3'd0}) & {32{mem_off_q != 2'd0}};
		case (mem_sz_q)
			2'd0: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
			2'd1: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
			default: ld_val = ld_raw;
		endcase
	end

	// divider result
	logic [31:0] div_res;
	logic [32:0] trial;
	assign trial = {drem_q[31:0], dd_q[31]} - {1'b0, dr_q};
	always_comb begin
		if (dspec_q) div_res = dspec_val_q;
		else if (dis_rem_q) div_res = drneg_q ? -drem_q[31:0] : drem_q[31:0];
		else div_res = dneg_q ? -dq_q : dq_q;
	end

	assign sts.clr_done = (clr_cnt_q == (WordAw + 1)'(MemWords - 1));
	assign sts.need_div = e_div;
	assign sts.need_mem = e_mem && !e_store;
	assign sts.div_done = dspec_q || dcnt_q == 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pc_q <= '0;
			halted_q <= 1'b0;
			valid <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			if (cmd.clr_step && !sts.clr_done) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.exec) begin
				pc_q <= e_npc;
				if (!halted_q && (e_status == ST_ILLEGAL || e_status == ST_BADADDR ||
						e_status == ST_EXIT)) halted_q <= 1'b1;
				if (e_wr && !e_div && !e_mem) rf_q[rd] <= e_val;
			end
			if (cmd.div_step && sts.div_done && rd != 5'd0) rf_q[rd] <= div_res;
			if (cmd.mem_finish && rd != 5'd0) rf_q[rd] <= ld_val;
			if (cmd.out_load) valid <= 1'b1;
			else if (!out_stall) valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) w_q <= instr_word;
		a_q <= rf_q[r1];
		b_q <= rf_q[r2];
		a0_q <= rf_q[10];
		a1_q <= rf_q[11];
		if (cmd.exec) begin
			r_status_q <= e_status;
			r_npc_q <= e_npc;
			r_wr_q <= e_wr;
			r_rd_q <= e_wr ? rd : 5'd0;
			r_val_q <= e_val;
			r_pv_q <= e_pv;
			mem_off_q <= base_lane;
			mem_sz_q <= f3[1:0];
		end
		if (cmd.div_step && sts.div_done) r_val_q <= (rd != 5'd0) ? div_res : 32'd0;
		if (cmd.mem_finish) r_val_q <= (rd != 5'd0) ? ld_val : 32'd0;
		if (cmd.div_start) begin
			dis_rem_q <= f3[1];
			dneg_q <= a_q[31] ^ b_q[31];
			drneg_q <= a_q[31];
			dd_q <= a_q[31] ? -a_q : a_q;
			dr_q <= b_q[31] ? -b_q : b_q;
			dq_q <= '0;
			drem_q <= '0;
			dcnt_q <= 6'd32;
			dspec_q <= (b_q == 32'd0);
			dspec_val_q <= f3[1] ? a_q : 32'hFFFF_FFFF;
		end else if (cmd.div_step && !sts.div_done) begin
			if (!trial[32]) drem_q <= trial;
			else drem_q <= {drem_q[31:0], dd_q[31]};
			dq_q <= {dq_q[30:0], !trial[32]};
			dd_q <= {dd_q[30:0], 1'b0};
			dcnt_q <= dcnt_q - 6'd1;
		end
		if (cmd.out_load) begin
			status <= r_status_q;
			next_pc <= r_npc_q;
			reg_write <= r_wr_q;
			dest_reg <= r_rd_q;
			write_value <= r_val_q;
			print_value <= r_pv_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_x0_zero: assert property (@(posedge clk) disable iff (!arst_n) rf_q[0] == 32'd0)
		else $error("x0 written");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted cleared");
	a_nowr_rd0: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !reg_write) |-> dest_reg == 5'd0)
		else $error("dest without write");
`endif
endmodule

// ===== sv/rv32im_subset_execute_unit.sv =====
// top level of the rv32im subset execute unit
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | instr_word
//  out     | out_valid | out_stall | status, next_pc, reg_write, dest_reg, write_value, print_value
// an item passes through take, register read, execute and output; loads add a memory step
// div and rem add a pass through the bit-serial divider
// after reset a clearing pass zeroes all 1024 words of data memory; no request is taken
// a stalled result holds the unit before it accepts the next request
module rv32im_subset_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instr_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [31:0]        next_pc,
	output logic               reg_write,
	output logic [4:0]         dest_reg,
	output logic [31:0]        write_value,
	output logic signed [31:0] print_value
);
	import rv_exu_pkg::*;

	exu_cmd_t cmd;
	exu_sts_t sts;

	rv_exu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rv_exu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_word  (instr_word),
		.cmd         (cmd),
		.out_stall   (out_stall),
		.sts         (sts),
		.valid       (out_valid),
		.status      (status),
		.next_pc     (next_pc),
		.reg_write   (reg_write),
		.dest_reg    (dest_reg),
		.write_value (write_value),
		.print_value (print_value)
	);
endmodule

// ===== sim/tb_rv32im_subset_execute_unit.sv =====
// testbench for the rv32im subset execute unit: scoreboard predictor, directed and random program stimulus
module tb_rv32im_subset_execute_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rv_exu_pkg::*;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR = 3'd5;
	localparam logic [2:0] F3_OR = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [2:0] F3_MUL = 3'd0;
	localparam logic [2:0] F3_MULH = 3'd1;
	localparam logic [2:0] F3_DIV = 3'd4;
	localparam logic [2:0] F3_REM = 3'd6;
	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_HALF = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_ALT = 7'd32;
	localparam logic [6:0] F7_MULDIV = 7'd1;
	localparam logic [31:0] CALL_PRINT = 32'd1;
	localparam logic [31:0] CALL_EXIT = 32'd10;
	localparam int A0 = 10;
	localparam int HIGH_BASE = 5;
	localparam int NUM_RANDOM = 720;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  dest_reg;
		logic [31:0] write_value;
		logic [31:0] print_value;
	} exu_result_t;

	class exu_scoreboard;
		logic [31:0] regs [32];
		logic [31:0] pc;
		logic [7:0]  mem [MemBytes];
		bit          halted;
		exu_result_t pending_results [$];
		int          errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			pc = '0;
			halted = 0;
			errors = 0;
		endfunction

		function bit fits(logic [31:0] addr, int size);
			return ({1'b0, addr} + 33'(size)) <= 33'(MemBytes);
		endfunction

		// execute one request against the shadow state and queue its result
		function void note_request(logic [31:0] w);
			exu_result_t r;
			logic [6:0]  op, f7;
			logic [4:0]  rd;
			logic [2:0]  f3;
			logic [31:0] a, b, val, imm, addr, npc;
			logic [63:0] prod;
			bit          wr, illegal;
			int          size;
			op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
			a = regs[w[19:15]]; b = regs[w[24:20]];
			npc = pc + 4; val = '0; wr = 0; illegal = 0;
			r.status = ST_OK; r.print_value = '0;
			if (halted) begin
				r.status = ST_HALTED;
				r.next_pc = pc; r.reg_write = 0; r.dest_reg = '0; r.write_value = '0;
				pending_results.push_back(r);
				return;
			end
			imm = {{20{w[31]}}, w[31:20]};
			case (op)
				OP_REG: begin
					wr = 1;
					if (f7 == F7_BASE) begin
						case (f3)
							F3_ADD: val = a + b;
							F3_SLL: val = a << b[4:0];
							F3_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
							F3_XOR: val = a ^ b;
							F3_SR: val = a >> b[4:0];
							F3_OR: val = a | b;
							F3_AND: val = a & b;
							default: illegal = 1;
						endcase
					end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
					else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[4:0];
					else if (f7 == F7_MULDIV && f3 == F3_MUL) val = a * b;
					else if (f7 == F7_MULDIV && f3 == F3_MULH) begin
						prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						val = prod[63:32];
					end else if (f7 == F7_MULDIV && (f3 == F3_DIV || f3 == F3_REM)) begin
						if (b == 0) val = (f3 == F3_DIV) ? 32'hffff_ffff : a;
						else if (a == 32'h8000_0000 && b == 32'hffff_ffff)
							val = (f3 == F3_DIV) ? a : 32'd0;
						else if (f3 == F3_DIV) val = $signed(a) / $signed(b);
						else val = $signed(a) % $signed(b);
					end else illegal = 1;
				end
				OP_IMM: begin
					wr = 1;
					case (f3)
						F3_ADD: val = a + imm;
						F3_SLL: if (f7 == F7_BASE) val = a << w[24:20]; else illegal = 1;
						F3_SLT: val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
						F3_XOR: val = a ^ imm;
						F3_SR: begin
							if (f7 == F7_BASE) val = a >> w[24:20];
							else if (f7 == F7_ALT) val = $signed(a) >>> w[24:20];
							else illegal = 1;
						end
						F3_OR: val = a | imm;
						F3_AND: val = a & imm;
						default: illegal = 1;
					endcase
				end
				OP_LOAD: begin
					addr = a + imm;
					if (f3 > F3_WORD) illegal = 1;
					else begin
						size = 1 << f3;
						if (!fits(addr, size)) r.status = ST_BADADDR;
						else begin
							for (int i = 0; i < size; i++)
								val |= 32'(mem[addr + i]) << (8 * i);
							if (size == 1) val = {{24{val[7]}}, val[7:0]};
							if (size == 2) val = {{16{val[15]}}, val[15:0]};
							wr = 1;
						end
					end
				end
				OP_STORE: begin
					addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
					if (f3 > F3_WORD) illegal = 1;
					else begin
						size = 1 << f3;
						if (!fits(addr, size)) r.status = ST_BADADDR;
						else for (int i = 0; i < size; i++) mem[addr + i] = b[8 * i +: 8];
					end
				end
				OP_BRANCH: begin
					imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
					if (f3 == F3_BEQ) begin
						if (a == b) npc = pc + imm;
					end else if (f3 == F3_BNE) begin
						if (a != b) npc = pc + imm;
					end else illegal = 1;
				end
				OP_JAL: begin
					wr = 1;
					val = pc + 4;
					npc = pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
				end
				OP_LUI: begin
					wr = 1;
					val = {w[31:12], 12'h000};
				end
				OP_SYSTEM: begin
					if (regs[A0] == CALL_PRINT) begin
						r.status = ST_PRINT;
						r.print_value = regs[11];
					end else if (regs[A0] == CALL_EXIT) begin
						r.status = ST_EXIT;
						halted = 1;
						npc = pc;
					end else illegal = 1;
				end
				default: illegal = 1;
			endcase
			if (illegal) r.status = ST_ILLEGAL;
			if (r.status == ST_ILLEGAL || r.status == ST_BADADDR) begin
				halted = 1; wr = 0; npc = pc;
			end
			if (rd == 0) wr = 0;
			if (wr) regs[rd] = val;
			else begin
				val = '0; rd = '0;
			end
			pc = npc;
			r.next_pc = npc; r.reg_write = wr; r.dest_reg = rd; r.write_value = val;
			pending_results.push_back(r);
		endfunction

		function void check_result(exu_result_t got);
			exu_result_t exp;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing outstanding: status %0d", got.status);
				return;
			end
			exp = pending_results.pop_front();
			if (got.status !== exp.status || got.next_pc !== exp.next_pc ||
					got.reg_write !== exp.reg_write || got.dest_reg !== exp.dest_reg ||
					got.write_value !== exp.write_value || got.print_value !== exp.print_value) begin
				errors++;
				if (errors <= 10) begin
					$write("mismatch: exp st %0d pc %h wr %b rd %0d val %h pv %h",
						exp.status, exp.next_pc, exp.reg_write, exp.dest_reg, exp.write_value,
						exp.print_value);
					$display(" / got st %0d pc %h wr %b rd %0d val %h pv %h",
						got.status, got.next_pc, got.reg_write, got.dest_reg,
						got.write_value, got.print_value);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        instr_word;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic [31:0]        next_pc;
	logic               reg_write;
	logic [4:0]         dest_reg;
	logic [31:0]        write_value;
	logic signed [31:0] print_value;

	exu_scoreboard sb = new();
	int  burst_left = 0;
	int  results_seen = 0;
	int  idle_cycles = 0;
	bit  hold_done = 0;

	rv32im_subset_execute_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .instr_word(instr_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .next_pc(next_pc), .reg_write(reg_write), .dest_reg(dest_reg),
		.write_value(write_value), .print_value(print_value)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function logic [31:0] r_word(logic [6:0] f7, int rs2, int rs1, logic [2:0] f3, int rd);
		return {f7, 5'(rs2), 5'(rs1), f3, 5'(rd), OP_REG};
	endfunction

	function logic [31:0] i_word(logic [6:0] op, logic [11:0] imm, int rs1, logic [2:0] f3,
			int rd);
		return {imm, 5'(rs1), f3, 5'(rd), op};
	endfunction

	function logic [31:0] s_word(logic [11:0] imm, int rs2, int rs1, logic [2:0] f3);
		return {imm[11:5], 5'(rs2), 5'(rs1), f3, imm[4:0], OP_STORE};
	endfunction

	function logic [31:0] b_word(logic [12:0] off, int rs2, int rs1, logic [2:0] f3);
		return {off[12], off[10:5], 5'(rs2), 5'(rs1), f3, off[4:1], off[11], OP_BRANCH};
	endfunction

	function logic [31:0] j_word(logic [20:0] off, int rd);
		return {off[20], off[10:1], off[11], off[19:12], 5'(rd), OP_JAL};
	endfunction

	function logic [31:0] u_word(logic [19:0] upper, int rd);
		return {upper, 5'(rd), OP_LUI};
	endfunction

	// pick base register and offset so the access stays inside memory
	function logic [31:0] mem_word(bit is_store, logic [2:0] f3);
		int          size, rs1;
		logic [31:0] target, diff;
		size = 1 << f3;
		target = $urandom_range(0, MemBytes - size);
		rs1 = ($urandom_range(0, 2) == 0) ? HIGH_BASE : $urandom_range(0, 31);
		diff = target - sb.regs[rs1];
		if ($signed(diff) > 2047 || $signed(diff) < -2048) begin
			rs1 = 0;
			diff = target % 2048;
		end
		if (is_store) return s_word(diff[11:0], $urandom_range(0, 31), rs1, f3);
		return i_word(OP_LOAD, diff[11:0], rs1, f3, $urandom_range(0, 31));
	endfunction

	function logic [31:0] random_word();
		int          rd, rs1, rs2;
		logic [31:0] w;
		logic [2:0]  f3s [7] = '{F3_ADD, F3_SLL, F3_SLT, F3_XOR, F3_SR, F3_OR, F3_AND};
		logic [2:0]  md [4] = '{F3_MUL, F3_MULH, F3_DIV, F3_REM};
		rd = $urandom_range(0, 31);
		if (rd == HIGH_BASE) rd = 6;
		rs1 = $urandom_range(0, 31);
		rs2 = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 31);
		w = $urandom();
		case ($urandom_range(0, 11))
			0: w = r_word(F7_BASE, rs2, rs1, f3s[$urandom_range(0, 6)], rd);
			1: w = r_word(F7_ALT, rs2, rs1, ($urandom_range(0, 1) ? F3_ADD : F3_SR), rd);
			2: w = r_word(F7_MULDIV, rs2, rs1, md[$urandom_range(0, 3)], rd);
			3: begin
				w = i_word(OP_IMM, w[11:0], rs1, f3s[$urandom_range(0, 6)], rd);
				if (w[14:12] == F3_SLL) w[31:25] = F7_BASE;
				if (w[14:12] == F3_SR) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
			end
			4: w = mem_word(0, 3'($urandom_range(0, 2)));
			5: w = mem_word(1, 3'($urandom_range(0, 2)));
			6: w = b_word(w[12:0], rs2, rs1, ($urandom_range(0, 1) ? F3_BEQ : F3_BNE));
			7: w = j_word(w[20:0], rd);
			8: w = u_word(w[19:0], rd);
			9: begin
				if (sb.regs[A0] == CALL_PRINT) w = {w[31:7], OP_SYSTEM};
				else w = i_word(OP_IMM, 12'(CALL_PRINT), 0, F3_ADD, A0);
			end
			default: w = mem_word($urandom_range(0, 1), 3'($urandom_range(0, 2)));
		endcase
		return w;
	endfunction

	// one request: optional gap, then offer until taken
	task automatic send_request(logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		instr_word <= w;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_request(w);
	endtask

	// receiver stall pattern, with one long hold-off
	initial begin
		int phase_left, level;
		out_stall = 1'b0;
		phase_left = 0; level = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 150) begin
				hold_done = 1;
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				level = $urandom_range(0, 3);
			end
			phase_left--;
			out_stall <= (level != 0) && ($urandom_range(0, 3) < level);
		end
	end

	always @(posedge clk) begin
		exu_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status; got.next_pc = next_pc; got.reg_write = reg_write;
			got.dest_reg = dest_reg; got.write_value = write_value;
			got.print_value = print_value;
			sb.check_result(got);
			results_seen++;
		end
	end

	// watchdog: cycles without progress while work is outstanding
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else if (arst_n && (in_valid || sb.pending_results.size() != 0)) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] directed [$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		instr_word = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		directed = '{
			u_word(20'd1, HIGH_BASE),
			i_word(OP_IMM, -12'sd4, HIGH_BASE, F3_ADD, HIGH_BASE),
			i_word(OP_IMM, 12'hfff, 0, F3_ADD, 6),
			i_word(OP_IMM, 12'h7ff, 0, F3_ADD, 7),
			u_word(20'h80000, 8),
			s_word(12'd0, 6, HIGH_BASE, F3_WORD),
			i_word(OP_LOAD, 12'd0, HIGH_BASE, F3_WORD, 9),
			i_word(OP_LOAD, 12'd3, HIGH_BASE, F3_BYTE, 11),
			i_word(OP_LOAD, 12'd2, HIGH_BASE, F3_HALF, 12),
			s_word(12'd0, 7, 0, F3_BYTE),
			s_word(12'd2045, 8, 0, F3_HALF),
			r_word(F7_MULDIV, 6, 8, F3_DIV, 13),
			r_word(F7_MULDIV, 6, 8, F3_REM, 14),
			r_word(F7_MULDIV, 0, 7, F3_DIV, 15),
			r_word(F7_MULDIV, 0, 7, F3_REM, 16),
			r_word(F7_MULDIV, 8, 8, F3_MULH, 17),
			r_word(F7_ALT, 6, 8, F3_SR, 18),
			{F7_ALT, 5'd31, 5'd8, F3_SR, 5'd19, OP_IMM},
			{F7_BASE, 5'd31, 5'd6, F3_SLL, 5'd20, OP_IMM},
			i_word(OP_IMM, 12'h800, 6, F3_SLT, 22),
			b_word(13'h1000, 0, 0, F3_BEQ),
			b_word(13'h0ffe, 0, 6, F3_BNE),
			j_word(21'h100000, 1),
			r_word(F7_BASE, 6, 6, F3_ADD, 0),
			i_word(OP_IMM, 12'(CALL_PRINT), 0, F3_ADD, A0),
			{25'h1ffffff, OP_SYSTEM}
		};
		foreach (directed[i]) send_request(directed[i]);
		repeat (NUM_RANDOM) send_request(random_word());

		// the unit halts for good, so one halting cause ends the run
		case ($urandom_range(0, 2))
			0: send_request({25'($urandom()), 7'h7f});
			1: send_request(i_word(OP_LOAD, 12'hffc, 0, F3_WORD, 1));
			default: begin
				send_request(i_word(OP_IMM, 12'(CALL_EXIT), 0, F3_ADD, A0));
				send_request({25'd0, OP_SYSTEM});
			end
		endcase
		repeat (4) send_request($urandom());
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
